FILE: hw/rtl/dbe_pkg.sv
`timescale 1ns / 1ps

package dbe_pkg;

  localparam int unsigned BUTTON_COUNT = 10;
  localparam int unsigned PIN_COUNT    = 16;

  // walk: buttons first, then encoder A, then encoder B
  localparam int unsigned STEP_COUNT = BUTTON_COUNT + 2;
  localparam int unsigned STEP_W     = $clog2(STEP_COUNT);
  localparam int unsigned PIN_W      = $clog2(PIN_COUNT);

  localparam logic [STEP_W-1:0] STEP_ENC_A = STEP_W'(BUTTON_COUNT);
  localparam logic [STEP_W-1:0] STEP_ENC_B = STEP_W'(BUTTON_COUNT + 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(STEP_COUNT - 1);

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned CHAN_W  = 5;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_DEB_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECK_A_CHAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECK_B_CHAN = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd30;
  localparam logic [CHAN_W-1:0] DECK_A_RESET   = 5'd1;
  localparam logic [CHAN_W-1:0] DECK_B_RESET   = 5'd2;
  localparam logic [CHAN_W-1:0] AUTOMIX_CHAN   = 5'd1;

  localparam logic [NOTE_W-1:0] NOTE_LOOP_A_SHIFT = 7'd60;
  localparam logic [NOTE_W-1:0] NOTE_LOOP_A       = 7'd61;
  localparam logic [NOTE_W-1:0] NOTE_LOOP_B_SHIFT = 7'd62;
  localparam logic [NOTE_W-1:0] NOTE_LOOP_B       = 7'd63;
  localparam logic [NOTE_W-1:0] NOTE_ENC_A_PLUS   = 7'd78;
  localparam logic [NOTE_W-1:0] NOTE_ENC_A_MINUS  = 7'd79;
  localparam logic [NOTE_W-1:0] NOTE_ENC_B_PLUS   = 7'd72;
  localparam logic [NOTE_W-1:0] NOTE_ENC_B_MINUS  = 7'd73;

  localparam logic [PIN_W-1:0] ENC_A_HI_PIN = 4'd13;
  localparam logic [PIN_W-1:0] ENC_A_LO_PIN = 4'd14;
  localparam logic [PIN_W-1:0] ENC_B_HI_PIN = 4'd1;
  localparam logic [PIN_W-1:0] ENC_B_LO_PIN = 4'd2;

  localparam logic [1:0] ENC_IDLE = 2'b00;
  localparam logic [1:0] ENC_FROM_PLUS  = 2'b10;
  localparam logic [1:0] ENC_FROM_MINUS = 2'b01;

  localparam logic [1:0] SHIFT_MAX = 2'd3;

  typedef enum logic [2:0] {
    ROLE_SHIFT,
    ROLE_LOOP_A,
    ROLE_LOOP_B,
    ROLE_NOTE_A,
    ROLE_NOTE_B,
    ROLE_CUEMIX,
    ROLE_AUTOMIX
  } role_e;

  typedef enum logic {
    EVT_NOTE_ON = 1'b0,
    EVT_CUE_MIX = 1'b1
  } evt_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } seq_e;

  typedef struct packed {
    logic [DEB_W-1:0]  deb_window;
    logic [CHAN_W-1:0] deck_a_channel;
    logic [CHAN_W-1:0] deck_b_channel;
  } cfg_t;

  typedef struct packed {
    logic              advance;
    logic [STEP_W-1:0] idx;
  } step_ctl_t;

  typedef struct packed {
    logic              valid;
    evt_kind_e         kind;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
  } event_t;

  function automatic logic [PIN_W-1:0] btn_pin(logic [STEP_W-1:0] idx);
    logic [PIN_W-1:0] p;
    unique case (idx)
      4'd0:    p = 4'd11;
      4'd1:    p = 4'd12;
      4'd2:    p = 4'd3;
      4'd3:    p = 4'd4;
      4'd4:    p = 4'd9;
      4'd5:    p = 4'd6;
      4'd6:    p = 4'd8;
      4'd7:    p = 4'd7;
      4'd8:    p = 4'd10;
      4'd9:    p = 4'd5;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic role_e btn_role(logic [STEP_W-1:0] idx);
    role_e r;
    unique case (idx)
      4'd0, 4'd2: r = ROLE_SHIFT;
      4'd1:       r = ROLE_LOOP_A;
      4'd3:       r = ROLE_LOOP_B;
      4'd4, 4'd6: r = ROLE_NOTE_A;
      4'd5, 4'd7: r = ROLE_NOTE_B;
      4'd8:       r = ROLE_CUEMIX;
      4'd9:       r = ROLE_AUTOMIX;
      default:    r = ROLE_SHIFT;
    endcase
    return r;
  endfunction

  function automatic logic [NOTE_W-1:0] btn_note(logic [STEP_W-1:0] idx);
    logic [NOTE_W-1:0] n;
    unique case (idx)
      4'd4:    n = 7'd20;
      4'd5:    n = 7'd21;
      4'd6:    n = 7'd22;
      4'd7:    n = 7'd23;
      4'd9:    n = 7'd91;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/dbe_scan_if.sv
`timescale 1ns / 1ps

interface dbe_scan_if;
  import dbe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIN_COUNT-1:0] pin_levels;
  logic [TIME_W-1:0]    now_ms;

  modport source (output valid, output pin_levels, output now_ms, input ready);
  modport sink   (input valid, input pin_levels, input now_ms, output ready);
endinterface

FILE: hw/rtl/dbe_event_if.sv
`timescale 1ns / 1ps

interface dbe_event_if;
  import dbe_pkg::*;

  logic              valid;
  logic              ready;
  logic              event_kind;
  logic [CHAN_W-1:0] channel;
  logic [NOTE_W-1:0] note;
  logic              last_of_scan;

  modport source (output valid, output event_kind, output channel, output note,
                  output last_of_scan, input ready);
  modport sink   (input valid, input event_kind, input channel, input note,
                  input last_of_scan, output ready);
endinterface

FILE: hw/rtl/dbe_cfg_if.sv
`timescale 1ns / 1ps

interface dbe_cfg_if;
  import dbe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/dbe_core.sv
`timescale 1ns / 1ps

// One walk step per cycle unless the walk is stalled: button debounce through a shared 32-bit
// subtract/compare, or an encoder check. State commits only on advance.
module dbe_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dbe_pkg::step_ctl_t                step_i,
  input  logic [dbe_pkg::PIN_COUNT-1:0]     pins_i,
  input  logic [dbe_pkg::TIME_W-1:0]        now_i,
  input  dbe_pkg::cfg_t                     cfg_i,
  output dbe_pkg::event_t                   event_o
);
  import dbe_pkg::*;

  logic [BUTTON_COUNT-1:0] deb_q, deb_d;
  logic [BUTTON_COUNT-1:0] prev_q, prev_d;
  logic [TIME_W-1:0]       ct_q [BUTTON_COUNT];
  logic [1:0]              shift_q, shift_d;
  logic [1:0]              enc_a_q, enc_a_d;
  logic [1:0]              enc_b_q, enc_b_d;

  logic              is_btn;
  logic              raw;
  logic              prev_r;
  logic              deb_r;
  logic [TIME_W-1:0] ct_r;
  logic [TIME_W-1:0] elapsed;
  logic              held_long;
  logic              accept;
  logic              ct_load;
  logic [1:0]        enc_now;
  role_e             role;

  // shared unit: wrap-safe elapsed time and compare against the window
  assign is_btn    = step_i.idx < STEP_W'(BUTTON_COUNT);
  assign raw       = ~pins_i[btn_pin(step_i.idx)];
  assign prev_r    = is_btn ? prev_q[step_i.idx] : 1'b0;
  assign deb_r     = is_btn ? deb_q[step_i.idx] : 1'b0;
  assign ct_r      = is_btn ? ct_q[step_i.idx] : '0;
  assign elapsed   = now_i - ct_r;
  assign held_long = elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg_i.deb_window};
  // a raw change restarts the window, so nothing is taken in that scan
  assign accept    = is_btn && (raw == prev_r) && held_long && (raw != deb_r);
  assign ct_load   = is_btn && (raw != prev_r);
  assign role      = btn_role(step_i.idx);
  assign enc_now   = (step_i.idx == STEP_ENC_A)
                     ? {pins_i[ENC_A_HI_PIN], pins_i[ENC_A_LO_PIN]}
                     : {pins_i[ENC_B_HI_PIN], pins_i[ENC_B_LO_PIN]};

  always_comb begin
    event_o = '{valid: 1'b0, kind: EVT_NOTE_ON, channel: '0, note: '0};
    deb_d   = deb_q;
    prev_d  = prev_q;
    shift_d = shift_q;
    enc_a_d = enc_a_q;
    enc_b_d = enc_b_q;

    if (is_btn) begin
      prev_d[step_i.idx] = raw;
      if (accept) begin
        deb_d[step_i.idx] = raw;
        if (raw) begin
          unique case (role)
            ROLE_SHIFT: begin
              if (shift_q != SHIFT_MAX) shift_d = shift_q + 2'd1;
            end
            ROLE_LOOP_A: begin
              event_o.valid   = 1'b1;
              event_o.channel = cfg_i.deck_a_channel;
              event_o.note    = (shift_q != 2'd0) ? NOTE_LOOP_A_SHIFT : NOTE_LOOP_A;
            end
            ROLE_LOOP_B: begin
              event_o.valid   = 1'b1;
              event_o.channel = cfg_i.deck_b_channel;
              event_o.note    = (shift_q != 2'd0) ? NOTE_LOOP_B_SHIFT : NOTE_LOOP_B;
            end
            ROLE_NOTE_A: begin
              event_o.valid   = 1'b1;
              event_o.channel = cfg_i.deck_a_channel;
              event_o.note    = btn_note(step_i.idx);
            end
            ROLE_NOTE_B: begin
              event_o.valid   = 1'b1;
              event_o.channel = cfg_i.deck_b_channel;
              event_o.note    = btn_note(step_i.idx);
            end
            ROLE_CUEMIX: begin
              event_o.valid = 1'b1;
              event_o.kind  = EVT_CUE_MIX;
            end
            default: begin
              event_o.valid   = 1'b1;
              event_o.channel = AUTOMIX_CHAN;
              event_o.note    = btn_note(step_i.idx);
            end
          endcase
        end else if (role == ROLE_SHIFT && shift_q != 2'd0) begin
          shift_d = shift_q - 2'd1;
        end
      end
    end else if (step_i.idx == STEP_ENC_A) begin
      enc_a_d = enc_now;
      if (enc_now == ENC_IDLE && (enc_a_q == ENC_FROM_PLUS || enc_a_q == ENC_FROM_MINUS)) begin
        event_o.valid   = 1'b1;
        event_o.channel = cfg_i.deck_a_channel;
        event_o.note    = (enc_a_q == ENC_FROM_PLUS) ? NOTE_ENC_A_PLUS : NOTE_ENC_A_MINUS;
      end
    end else if (step_i.idx == STEP_ENC_B) begin
      enc_b_d = enc_now;
      if (enc_now == ENC_IDLE && (enc_b_q == ENC_FROM_PLUS || enc_b_q == ENC_FROM_MINUS)) begin
        event_o.valid   = 1'b1;
        event_o.channel = cfg_i.deck_b_channel;
        event_o.note    = (enc_b_q == ENC_FROM_PLUS) ? NOTE_ENC_B_PLUS : NOTE_ENC_B_MINUS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= '0;
      prev_q  <= '0;
      shift_q <= '0;
      enc_a_q <= '0;
      enc_b_q <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        ct_q[i] <= '0;
      end
    end else if (step_i.advance) begin
      deb_q   <= deb_d;
      prev_q  <= prev_d;
      shift_q <= shift_d;
      enc_a_q <= enc_a_d;
      enc_b_q <= enc_b_d;
      if (ct_load) begin
        ct_q[step_i.idx] <= now_i;
      end
    end
  end

endmodule

FILE: hw/rtl/debounced_buttons_and_encoder_events_top.sv
`timescale 1ns / 1ps

// Button debounce and quadrature encoder event generator.
// scan_i: one request per scan of 16 raw pins (buttons active low) plus a
//   millisecond timestamp. Ready only while the block is idle.
// evt_o: zero to ten event requests per scan (note-on or cue mix toggle),
//   in button table order then encoder A, encoder B; last_of_scan marks the
//   final one. A scan with no events gives nothing on evt_o.
// cfg_i: register writes (0 debounce window, 1 deck A channel, 2 deck B
//   channel), always ready; write only while idle.
// Timing: a scan is walked one table entry per cycle through a shared
//   32-bit subtract/compare while evt_o keeps up; the flush state then
//   pushes out any staged event. Each event goes from the staging
//   register to the output register and is held in staging until the
//   next event or the flush, so the last one can be flagged.
// Stall: a blocked evt_o freezes the walk when a new event comes while the
//   output and staging registers both hold events; none is lost or repeated.
// Reset: all buttons released, change times and encoders zero, shift count
//   zero, registers at 30 ms / channel 1 / channel 2.
module debounced_buttons_and_encoder_events_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbe_scan_if.sink    scan_i,
  dbe_event_if.source evt_o,
  dbe_cfg_if.sink     cfg_i
);
  import dbe_pkg::*;

  seq_e              state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PIN_COUNT-1:0] pins_q;
  logic [TIME_W-1:0] now_q;
  cfg_t              cfg_q;

  event_t            core_ev;
  step_ctl_t         step_ctl;

  // staging register: newest event, not yet known to be last
  logic              pend_valid_q;
  event_t            pend_q;
  // output register
  logic              out_valid_q;
  event_t            out_q;
  logic              out_last_q;

  logic scan_take;
  logic out_free;
  logic advance;
  logic push;
  logic push_last;
  logic pend_load;
  logic pend_clear;

  assign scan_take = scan_i.valid && scan_i.ready;
  assign out_free  = !out_valid_q || evt_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (scan_take) state_d = S_WALK;
      end
      S_WALK: begin
        if (advance && step_q == STEP_LAST) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    advance    = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    step_d     = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (scan_take) step_d = '0;
      end
      S_WALK: begin
        // stall only when a new event must push the staged one out
        advance = !(core_ev.valid && pend_valid_q && !out_free);
        if (advance) begin
          step_d = step_q + STEP_W'(1);
          if (core_ev.valid) begin
            pend_load = 1'b1;
            push      = pend_valid_q;
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid_q && out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign step_ctl = '{advance: advance, idx: step_q};

  dbe_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_ctl),
    .pins_i  (pins_q),
    .now_i   (now_q),
    .cfg_i   (cfg_q),
    .event_o (core_ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (pend_clear) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_take) begin
      pins_q <= scan_i.pin_levels;
      now_q  <= scan_i.now_ms;
    end
    if (pend_load) pend_q <= core_ev;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{deb_window: DEBOUNCE_RESET, deck_a_channel: DECK_A_RESET,
                 deck_b_channel: DECK_B_RESET};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEB_WINDOW:  cfg_q.deb_window     <= cfg_i.data;
        REG_DECK_A_CHAN: cfg_q.deck_a_channel <= cfg_i.data[CHAN_W-1:0];
        REG_DECK_B_CHAN: cfg_q.deck_b_channel <= cfg_i.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign scan_i.ready       = (state_q == S_IDLE);
  assign evt_o.valid        = out_valid_q;
  assign evt_o.event_kind   = out_q.kind;
  assign evt_o.channel      = out_q.channel;
  assign evt_o.note         = out_q.note;
  assign evt_o.last_of_scan = out_last_q;

`ifndef SYNTH
  // nothing may stay staged once the block reports idle
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("staged event left over in idle");

  // the final step of a walk always moves on to the flush
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && advance && step_q == STEP_LAST) |=> state_q == S_FLUSH)
    else $error("walk did not end in flush");

  // last-of-scan is only flagged from the flush, never mid-walk
  a_last_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_last) |-> state_q == S_FLUSH)
    else $error("last flag set outside flush");

  // a stalled walk never drops the staged event
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !advance) |=> pend_valid_q && out_valid_q)
    else $error("stall lost an event");
`endif

endmodule
